// ----- hw/rtl/wsdi_pkg.sv -----
// shared types, constants and tables for the snr to db index block
package wsdi_pkg;

  localparam int LOG_ENTRIES  = 64;
  localparam int IDX_W        = $clog2(LOG_ENTRIES);
  localparam int SEARCH_STEPS = $clog2(LOG_ENTRIES) + 1;
  localparam int DIV_W        = 32;
  localparam int ROM_W        = DIV_W + 1;
  localparam int NUM_W        = 25;
  localparam int PROD_W       = 8 + NUM_W;
  localparam int SNR_W        = 7;
  localparam int FRAC_DIGITS  = 15;
  localparam int LATENCY      = 1 + DIV_W + SEARCH_STEPS;

  localparam logic [NUM_W-1:0] NUM_SCALE = NUM_W'(17578125);
  localparam logic [ROM_W-1:0] ROM_SAT   = {1'b1, {DIV_W{1'b0}}};

  // (m + 8) * 281250000 for the three bit mantissa m
  localparam logic [DIV_W-1:0] DEN_TAB [8] = '{
    32'd2250000000, 32'd2531250000, 32'd2812500000, 32'd3093750000,
    32'd3375000000, 32'd3656250000, 32'd3937500000, 32'd4218750000
  };

  localparam logic signed [SNR_W-1:0] QUALITY_TAB [8] = '{
    -7'sd6, -7'sd5, -7'sd4, 7'sd0, -7'sd1, 7'sd2, 7'sd5, 7'sd8
  };

  // floor(10^(r/10) * 10^15)
  localparam logic [63:0] TENTH_POW [10] = '{
    64'd1000000000000000, 64'd1258925411794167, 64'd1584893192461113,
    64'd1995262314968879, 64'd2511886431509580, 64'd3162277660168379,
    64'd3981071705534972, 64'd5011872336272722, 64'd6309573444801932,
    64'd7943282347242815
  };

  typedef logic [ROM_W-1:0] rom_t [LOG_ENTRIES];

  // floor(10^(i/10)), saturated above the quotient range
  function automatic rom_t build_rom();
    rom_t        r;
    logic [63:0] v;
    int          q;
    for (int i = 0; i < LOG_ENTRIES; i++) begin
      q = i / 10;
      v = TENTH_POW[i % 10];
      for (int k = q; k < FRAC_DIGITS; k++) begin
        v = v / 10;
      end
      if (q > FRAC_DIGITS || v >= 64'(ROM_SAT)) begin
        r[i] = ROM_SAT;
      end else begin
        r[i] = ROM_W'(v);
      end
    end
    return r;
  endfunction

  localparam rom_t LOG_ROM = build_rom();

  typedef struct packed {
    logic [7:0] snr_nibble;
    logic [7:0] mantissa_byte;
    logic [7:0] exponent_byte;
  } cmd_t;

  typedef struct packed {
    logic signed [SNR_W-1:0] snr_db;
    logic                    used_fallback;
    logic                    bad_nibble;
  } result_t;

  typedef struct packed {
    logic                    used_fallback;
    logic                    bad_nibble;
    logic signed [SNR_W-1:0] fb_db;
  } side_t;

  typedef struct packed {
    logic             valid;
    side_t            side;
    logic [DIV_W-1:0] rem;
    logic [DIV_W-1:0] dq;
    logic [DIV_W-1:0] den;
  } div_stage_t;

  typedef struct packed {
    logic             valid;
    side_t            side;
    logic [DIV_W-1:0] quo;
    logic [IDX_W-1:0] lo;
    logic [IDX_W-1:0] hi;
    logic [IDX_W-1:0] nxt;
    logic [IDX_W-1:0] idx;
    logic             fin;
  } srch_t;

endpackage

// ----- hw/rtl/wsdi_div_cell.sv -----
// one restoring divider cell: one quotient bit per item
module wsdi_div_cell (
  input  logic                   clk,
  input  logic                   rst,
  input  wsdi_pkg::div_stage_t   din,
  output wsdi_pkg::div_stage_t   dout
);
  import wsdi_pkg::*;

  logic [DIV_W:0] trial;
  logic [DIV_W:0] diff;
  logic           take;
  div_stage_t     dout_next;

  assign trial = {din.rem, din.dq[DIV_W-1]};
  assign diff  = trial - {1'b0, din.den};
  assign take  = trial >= {1'b0, din.den};

  always_comb begin
    dout_next     = din;
    dout_next.rem = take ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
    dout_next.dq  = {din.dq[DIV_W-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout <= '0;
    end else begin
      dout <= dout_next;
    end
  end

endmodule

// ----- hw/rtl/wsdi_search_cell.sv -----
// one binary search step over the db table
module wsdi_search_cell (
  input  logic              clk,
  input  logic              rst,
  input  wsdi_pkg::srch_t   din,
  output wsdi_pkg::srch_t   dout
);
  import wsdi_pkg::*;

  logic [IDX_W:0] sum;
  srch_t          dout_next;

  always_comb begin
    dout_next = din;
    sum       = '0;
    if (!din.fin) begin
      dout_next.idx = din.nxt;
      if ({1'b0, din.quo} >= LOG_ROM[din.nxt]) begin
        dout_next.lo = din.nxt;
        sum          = {1'b0, din.nxt} + {1'b0, din.hi};
      end else begin
        dout_next.hi = din.nxt;
        sum          = {1'b0, din.nxt} + {1'b0, din.lo};
      end
      dout_next.nxt = sum[IDX_W:1];
      dout_next.fin = (sum[IDX_W:1] == din.nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout <= '0;
    end else begin
      dout <= dout_next;
    end
  end

endmodule

// ----- hw/rtl/wlan_snr_db_index.sv -----
// snr to db index: operand stage, divider cell chain, search cell chain
// an accepted item passes one operand stage, one divider cell per quotient bit and one
// search cell per step (64-entry table) on its way to done
// throughput: one item per cycle while busy is low; the receiver cannot stall
// busy is high only during reset; reset clears the valid bits of every stage
// result ports hold each result for the single cycle that done is high
module wlan_snr_db_index (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  wsdi_pkg::cmd_t    cmd,
  output logic              done,
  output wsdi_pkg::result_t result
);
  import wsdi_pkg::*;

  div_stage_t        dpipe [DIV_W+1];
  srch_t             spipe [SEARCH_STEPS+1];
  div_stage_t        front_next;
  logic [PROD_W-1:0] prod;
  srch_t             last;

  assign busy = rst;
  assign prod = PROD_W'(cmd.mantissa_byte) * PROD_W'(NUM_SCALE);

  always_comb begin
    front_next.valid              = start && !busy;
    front_next.side.used_fallback = (cmd.mantissa_byte == 8'd0) && (cmd.exponent_byte == 8'd0);
    front_next.side.bad_nibble    = front_next.side.used_fallback && !cmd.snr_nibble[3];
    front_next.side.fb_db         = '0;
    if (front_next.side.used_fallback && cmd.snr_nibble[3]) begin
      front_next.side.fb_db = QUALITY_TAB[cmd.snr_nibble[2:0]];
    end
    front_next.rem = '0;
    front_next.dq  = prod[PROD_W-1:1];
    front_next.den = DEN_TAB[cmd.exponent_byte[7:5]] >> cmd.exponent_byte[4:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dpipe[0] <= '0;
    end else begin
      dpipe[0] <= front_next;
    end
  end

  for (genvar g = 0; g < DIV_W; g++) begin : g_div
    wsdi_div_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .din  (dpipe[g]),
      .dout (dpipe[g+1])
    );
  end

  // start the search over the whole table
  always_comb begin
    spipe[0].valid = dpipe[DIV_W].valid;
    spipe[0].side  = dpipe[DIV_W].side;
    spipe[0].quo   = dpipe[DIV_W].dq;
    spipe[0].lo    = '0;
    spipe[0].hi    = IDX_W'(LOG_ENTRIES - 1);
    spipe[0].nxt   = IDX_W'(LOG_ENTRIES / 2);
    spipe[0].idx   = '0;
    spipe[0].fin   = 1'b0;
  end

  for (genvar g = 0; g < SEARCH_STEPS; g++) begin : g_srch
    wsdi_search_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .din  (spipe[g]),
      .dout (spipe[g+1])
    );
  end

  assign last                 = spipe[SEARCH_STEPS];
  assign done                 = last.valid;
  assign result.used_fallback = last.side.used_fallback;
  assign result.bad_nibble    = last.side.bad_nibble;
  assign result.snr_db        = last.side.used_fallback ? last.side.fb_db
                                                        : signed'(SNR_W'(last.idx));

endmodule

// ----- hw/rtl/wsdi_checker.sv -----
// port level checks for the snr to db index block
module wsdi_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input wsdi_pkg::cmd_t    cmd,
  input logic              done,
  input wsdi_pkg::result_t result
);
  import wsdi_pkg::*;

  // every accepted item comes out after the fixed latency
  a_latency : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("item lost in pipeline");

  // no result without an item accepted at the fixed latency before
  a_no_extra : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result without item");

  a_bad_implies_fb : assert property (@(posedge clk) disable iff (rst)
    (done && result.bad_nibble) |-> (result.used_fallback && result.snr_db == '0))
    else $error("bad nibble without fallback or nonzero value");

  // fallback result follows the fallback condition of its item
  a_fb_match : assert property (@(posedge clk) disable iff (rst)
    done |-> (result.used_fallback ==
              ($past(cmd.mantissa_byte, LATENCY) == 8'd0 &&
               $past(cmd.exponent_byte, LATENCY) == 8'd0)))
    else $error("fallback flag mismatch");

endmodule

bind wlan_snr_db_index wsdi_checker u_chk (.*);

// ----- verif/tb.sv -----
// self-checking testbench for the snr to db index block
module tb;
  import wsdi_pkg::*;

  localparam int ROM_DEPTH        = LOG_ENTRIES;
  localparam int RANDOM_PER_PHASE = 376;
  localparam int IDLE_PCT [3]     = '{0, 48, 19};

  localparam logic [63:0] TENTH_POWERS [10] = '{
    64'd1000000000000000, 64'd1258925411794167, 64'd1584893192461113,
    64'd1995262314968879, 64'd2511886431509580, 64'd3162277660168379,
    64'd3981071705534972, 64'd5011872336272722, 64'd6309573444801932,
    64'd7943282347242815
  };

  localparam logic signed [SNR_W-1:0] LINK_QUALITY [8] = '{
    -7'sd6, -7'sd5, -7'sd4, 7'sd0, -7'sd1, 7'sd2, 7'sd5, 7'sd8
  };

  class snr_scoreboard;
    result_t expected_db[$];
    int      errors;

    // floor(10^(i/10))
    function automatic logic [63:0] db_threshold(int i);
      logic [63:0] v;
      v = TENTH_POWERS[i % 10];
      for (int k = i / 10; k < 15; k++) begin
        v = v / 10;
      end
      return v;
    endfunction

    function automatic result_t predict_snr_db(cmd_t c);
      result_t     r;
      logic [63:0] num;
      logic [63:0] den;
      logic [63:0] quo;
      int          lo;
      int          hi;
      int          nxt;
      int          idx;
      r = '0;
      if (c.mantissa_byte == 8'd0 && c.exponent_byte == 8'd0) begin
        r.used_fallback = 1'b1;
        if (!c.snr_nibble[3]) begin
          r.bad_nibble = 1'b1;
        end else begin
          r.snr_db = LINK_QUALITY[c.snr_nibble[2:0]];
        end
      end else begin
        num = (64'(c.mantissa_byte) * 64'd17578125) >> 1;
        den = ((64'(c.exponent_byte[7:5]) + 64'd8) * 64'd281250000) >> c.exponent_byte[4:0];
        quo = num / den;
        lo  = 0;
        hi  = ROM_DEPTH - 1;
        nxt = ROM_DEPTH / 2;
        idx = 0;
        for (int step = 0; step < 64; step++) begin
          idx = nxt;
          if (quo >= db_threshold(idx)) begin
            lo  = idx;
            nxt = (idx + hi) / 2;
          end else begin
            hi  = idx;
            nxt = (idx + lo) / 2;
          end
          if (nxt == idx) break;
        end
        r.snr_db = SNR_W'(idx);
      end
      return r;
    endfunction

    function void note_item(cmd_t c);
      expected_db.push_back(predict_snr_db(c));
    endfunction

    function void check_result(result_t r);
      result_t e;
      if (expected_db.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, r);
        errors++;
        return;
      end
      e = expected_db.pop_front();
      if (r.snr_db !== e.snr_db) begin
        $display("%0t: snr_db expected %0d, actual %0d", $time, e.snr_db, r.snr_db);
        errors++;
      end
      if (r.used_fallback !== e.used_fallback) begin
        $display("%0t: used_fallback expected %0b, actual %0b", $time,
                 e.used_fallback, r.used_fallback);
        errors++;
      end
      if (r.bad_nibble !== e.bad_nibble) begin
        $display("%0t: bad_nibble expected %0b, actual %0b", $time,
                 e.bad_nibble, r.bad_nibble);
        errors++;
      end
    endfunction
  endclass

  logic    clk = 1'b0;
  logic    rst;
  logic    start;
  logic    busy;
  cmd_t    cmd;
  logic    done;
  result_t result;

  snr_scoreboard sb;

  wlan_snr_db_index dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .result (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) sb.note_item(cmd);
      if (done) sb.check_result(result);
    end
  end

  function automatic cmd_t make_cmd(logic [7:0] nib, logic [7:0] man, logic [7:0] expo);
    cmd_t c;
    c.snr_nibble    = nib;
    c.mantissa_byte = man;
    c.exponent_byte = expo;
    return c;
  endfunction

  task automatic send_item(cmd_t c);
    start <= 1'b1;
    cmd   <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic hold_off(int n);
    start <= 1'b0;
    cmd   <= cmd_t'(24'($urandom));
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (sb.expected_db.size() != 0);
  endtask

  initial begin
    cmd_t c;
    int   pick;
    sb    = new();
    rst   = 1'b1;
    start = 1'b0;
    cmd   = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // every fallback nibble, upper bits random
    for (int n = 0; n < 16; n++) begin
      send_item(make_cmd({4'($urandom), 4'(n)}, 8'd0, 8'd0));
    end
    send_item(make_cmd(8'hff, 8'd255, 8'h00));
    send_item(make_cmd(8'h00, 8'd255, 8'h1f));
    send_item(make_cmd(8'h5a, 8'd255, 8'hff));
    send_item(make_cmd(8'ha5, 8'd0, 8'hff));
    send_item(make_cmd(8'h0f, 8'd0, 8'h01));
    send_item(make_cmd(8'hf0, 8'd1, 8'h00));
    send_item(make_cmd(8'h33, 8'd1, 8'h1f));
    drain();

    foreach (IDLE_PCT[p]) begin
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        c    = cmd_t'(24'($urandom));
        pick = $urandom_range(99);
        if (pick < 10) begin
          c.mantissa_byte = '0;
          c.exponent_byte = '0;
        end else if (pick < 15) begin
          c.mantissa_byte = '0;
        end else if (pick < 20) begin
          c.exponent_byte = '0;
        end
        send_item(c);
        while ($urandom_range(99) < IDLE_PCT[p]) hold_off(1);
      end
      drain();
    end

    repeat (LATENCY + 8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/wsdi_pkg.sv
hw/rtl/wsdi_div_cell.sv
hw/rtl/wsdi_search_cell.sv
hw/rtl/wlan_snr_db_index.sv
hw/rtl/wsdi_checker.sv
verif/tb.sv
